// File: rtl/core/sso_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Step sequencer sine oscillator package
// Shared sizes, fixed-point constants, the sine ROM contents and the
// step-table write word.
// ----------------------------------------------------------------------------
package sso_pkg;

  localparam int STEP_COUNT       = 8;
  localparam int STEP_W           = (STEP_COUNT > 1) ? $clog2(STEP_COUNT) : 1;
  localparam int SINE_TABLE_DEPTH = 256;
  localparam int SINE_ADDR_W      = $clog2(SINE_TABLE_DEPTH);

  localparam int PHASE_W    = 32;
  localparam int FREQ_W     = 16;
  localparam int INTERVAL_W = 16;
  localparam int SAMPLE_W   = 16;
  localparam int STEP_IN_W  = 3;
  localparam int STEP_OUT_W = 3;

  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd150;

  // Phase increment = round(f * 2^28 / fs), split as
  // f * Q + floor((f * R + fs/2) / fs) with 2^28 = fs * Q + R.
  localparam longint unsigned SAMPLE_RATE_HZ = 64'd44100;
  localparam longint unsigned TURN_Q28       = 64'd1 << 28;
  localparam int              INC_W          = 29;
  localparam logic [12:0]     INC_Q          = 13'(TURN_Q28 / SAMPLE_RATE_HZ);
  localparam logic [15:0]     INC_R          = 16'(TURN_Q28 % SAMPLE_RATE_HZ);
  localparam logic [14:0]     INC_HALF       = 15'(SAMPLE_RATE_HZ / 2);

  // The remainder term is divided by fs as a shift by two followed by a
  // reciprocal multiply that is exact for every 30-bit dividend.
  localparam longint unsigned RATE_QUARTER = SAMPLE_RATE_HZ / 4;
  localparam int              RECIP_SHIFT  = 44;
  localparam logic [30:0]     INC_RECIP    =
    31'(((64'd1 << RECIP_SHIFT) + RATE_QUARTER - 1) / RATE_QUARTER);

  typedef struct packed {
    logic              en;
    logic [STEP_W-1:0] addr;
    logic [INC_W-1:0]  data;
  } step_wr_t;

  typedef logic [SINE_TABLE_DEPTH-1:0][SAMPLE_W-1:0] sine_rom_t;

  localparam longint unsigned Q30_ONE     = 64'd1 << 30;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // Builds the sine ROM at elaboration: quarter-wave folding, then an odd
  // Taylor series to x^11 by Horner in unsigned Q30 with truncation.
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t       rom;
    longint unsigned t;
    longint unsigned u;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned s;
    longint unsigned amp;
    longint unsigned quad;
    for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
      t    = (64'(k) << 32) / 64'(SINE_TABLE_DEPTH);
      quad = (t >> 30) & 64'd3;
      u    = t & (Q30_ONE - 64'd1);
      if (quad[0]) begin
        u = Q30_ONE - u;
      end
      x    = (u * HALF_PI_Q30) >> 30;
      x2   = (x * x) >> 30;
      term = Q30_ONE - x2 / 64'd110;
      term = Q30_ONE - ((x2 * term) >> 30) / 64'd72;
      term = Q30_ONE - ((x2 * term) >> 30) / 64'd42;
      term = Q30_ONE - ((x2 * term) >> 30) / 64'd20;
      term = Q30_ONE - ((x2 * term) >> 30) / 64'd6;
      s    = (x * term) >> 30;
      amp  = (s * 64'd32767 + (Q30_ONE >> 1)) >> 30;
      if (amp > 64'd32767) begin
        amp = 64'd32767;
      end
      if (quad[1]) begin
        rom[k] = 16'(64'h10000 - amp);
      end else begin
        rom[k] = 16'(amp);
      end
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

// File: rtl/core/step_sequencer_sine_oscillator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Step sequencer sine oscillator
// Millisecond-paced step sequencer whose current step frequency drives a
// 32-bit phase accumulator and a 256-entry sine ROM.
// ----------------------------------------------------------------------------
// Sample words (tuser low) are taken one per cycle while in_tready is high,
// and each gives one output word, registered in the RAM read stage and then
// written into the output queue; the step RAM read and the phase update form
// a two-stage loop that keeps pace with one word a cycle. A frequency write
// word (tuser high) gives no output; it passes through the three-stage
// increment converter to the step RAM, and in_tready stays low until then.
// The step table reads as zero after reset through per-step valid bits, so no
// clearing pass is needed. A four-word output queue decouples the two sides.
module step_sequencer_sine_oscillator
  import sso_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: ms_strobe [0], step_index [3:1], new_frequency [19:4]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,
  // in_tuser: command [0]
  input  logic        in_tuser,
  // out_tdata: sample [15:0], current_step_out [18:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,
  // out_tuser: step_tick [0]
  output logic        out_tuser,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W = OUT_PTR_W + 1;

  typedef struct packed {
    logic [SAMPLE_W-1:0]   sample;
    logic [STEP_OUT_W-1:0] step;
    logic                  tick;
  } out_word_t;

  logic                  in_ms_strobe;
  logic [STEP_IN_W-1:0]  in_step_index;
  logic [FREQ_W-1:0]     in_new_frequency;

  logic [INTERVAL_W-1:0] interval_r;
  logic [INTERVAL_W-1:0] elapsed_r;
  logic [INTERVAL_W-1:0] elapsed_inc;
  logic [INTERVAL_W-1:0] elapsed_nxt;
  logic [STEP_W-1:0]     step_r;
  logic [STEP_W-1:0]     step_nxt;
  logic                  advance;
  logic [STEP_COUNT-1:0] step_valid_r;
  logic [PHASE_W-1:0]    phase_r;

  logic                  in_acc;
  logic                  sample_acc;
  logic                  write_acc;
  logic                  wr_busy;
  step_wr_t              ram_wr;
  logic [INC_W-1:0]      ram_q;

  logic                  s1_valid_r;
  logic                  s1_tick_r;
  logic [STEP_W-1:0]     s1_step_r;
  logic                  s1_entry_valid_r;
  logic [PHASE_W-1:0]    s1_inc;

  out_word_t             fifo_r [OUT_DEPTH];
  logic [OUT_PTR_W-1:0]  wr_ptr_r;
  logic [OUT_PTR_W-1:0]  rd_ptr_r;
  logic [OUT_CNT_W-1:0]  count_r;
  logic [OUT_CNT_W-1:0]  count_nxt;
  logic                  pop;
  out_word_t             push_word;
  out_word_t             head_word;

  assign in_ms_strobe     = in_tdata[0];
  assign in_step_index    = in_tdata[3:1];
  assign in_new_frequency = in_tdata[19:4];

  // Room is counted for the word still in the RAM read stage as well.
  assign in_tready  = !wr_busy &&
                      ((count_r + OUT_CNT_W'(s1_valid_r)) < OUT_CNT_W'(OUT_DEPTH));
  assign in_acc     = in_tvalid && in_tready;
  assign sample_acc = in_acc && !in_tuser;
  assign write_acc  = in_acc && in_tuser &&
                      (32'(in_step_index) < 32'(STEP_COUNT));

  always_comb begin
    elapsed_inc = elapsed_r;
    if (in_ms_strobe && (elapsed_r != '1)) begin
      elapsed_inc = elapsed_r + 1'b1;
    end
    advance     = elapsed_inc > interval_r;
    elapsed_nxt = advance ? '0 : elapsed_inc;
    step_nxt    = step_r;
    if (advance) begin
      if (step_r == STEP_W'(STEP_COUNT - 1)) begin
        step_nxt = '0;
      end else begin
        step_nxt = step_r + 1'b1;
      end
    end
  end

  sso_incr u_incr (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (write_acc),
    .req_addr  (STEP_W'(in_step_index)),
    .req_freq  (in_new_frequency),
    .wr        (ram_wr),
    .busy      (wr_busy)
  );

  sso_ram #(
    .WIDTH (INC_W),
    .DEPTH (STEP_COUNT)
  ) u_step_ram (
    .clk     (clk),
    .wr_en   (ram_wr.en),
    .wr_addr (ram_wr.addr),
    .wr_data (ram_wr.data),
    .rd_en   (sample_acc),
    .rd_addr (step_nxt),
    .rd_data (ram_q)
  );

  assign s1_inc = s1_entry_valid_r ? PHASE_W'(ram_q) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r   <= INTERVAL_RESET;
      elapsed_r    <= '0;
      step_r       <= '0;
      step_valid_r <= '0;
      phase_r      <= '0;
      s1_valid_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        interval_r <= cfg_wr_data;
      end
      if (sample_acc) begin
        elapsed_r <= elapsed_nxt;
        step_r    <= step_nxt;
      end
      if (ram_wr.en) begin
        step_valid_r[ram_wr.addr] <= 1'b1;
      end
      if (s1_valid_r) begin
        phase_r <= phase_r + s1_inc;
      end
      s1_valid_r <= sample_acc;
    end
    if (sample_acc) begin
      s1_tick_r        <= advance;
      s1_step_r        <= step_nxt;
      s1_entry_valid_r <= step_valid_r[step_nxt];
    end
  end

  // The sample is taken from the phase before this word's increment lands.
  assign push_word.sample = SINE_ROM[phase_r[PHASE_W-1 -: SINE_ADDR_W]];
  assign push_word.step   = STEP_OUT_W'(s1_step_r);
  assign push_word.tick   = s1_tick_r;

  assign pop       = out_tvalid && out_tready;
  assign head_word = fifo_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    unique case ({s1_valid_r, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (s1_valid_r) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
    if (s1_valid_r) begin
      fifo_r[wr_ptr_r] <= push_word;
    end
  end

  assign out_tvalid = count_r != '0;
  assign out_tdata  = {5'd0, head_word.step, head_word.sample};
  assign out_tuser  = head_word.tick;

  a_no_queue_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(s1_valid_r && !pop && (count_r == OUT_CNT_W'(OUT_DEPTH))))
    else $error("output queue overflow");

  a_sample_reaches_stage: assert property (@(posedge clk) disable iff (!rst_n)
    sample_acc |=> s1_valid_r)
    else $error("accepted sample word lost before the RAM stage");

  a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(step_r) < 32'(STEP_COUNT))
    else $error("current step out of range");

  a_tick_moves_step: assert property (@(posedge clk) disable iff (!rst_n)
    (sample_acc && advance) |=> (step_r != $past(step_r)))
    else $error("step tick without step change");

  a_no_read_during_update: assert property (@(posedge clk) disable iff (!rst_n)
    ram_wr.en |-> !sample_acc)
    else $error("step RAM read while an update is pending");

endmodule

// File: rtl/core/sso_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module sso_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/core/sso_incr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Phase increment converter
// Three-stage pipeline turning a step frequency in 1/16 Hz into a rounded
// 32-bit-turn phase increment, ready to be written into the step RAM.
// ----------------------------------------------------------------------------
module sso_incr
  import sso_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              req_valid,
  input  logic [STEP_W-1:0] req_addr,
  input  logic [FREQ_W-1:0] req_freq,
  output step_wr_t          wr,
  output logic              busy
);

  localparam int PROD_W = 61;

  logic              s1_valid_r;
  logic [STEP_W-1:0] s1_addr_r;
  logic [INC_W-1:0]  fq_r;
  logic [31:0]       v_r;

  logic              s2_valid_r;
  logic [STEP_W-1:0] s2_addr_r;
  logic [INC_W-1:0]  fq2_r;
  logic [PROD_W-1:0] prod_r;

  step_wr_t          wr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      wr_r.en    <= 1'b0;
    end else begin
      s1_valid_r <= req_valid;
      s2_valid_r <= s1_valid_r;
      wr_r.en    <= s2_valid_r;
    end
    s1_addr_r <= req_addr;
    fq_r      <= INC_W'(req_freq) * INC_W'(INC_Q);
    v_r       <= 32'(req_freq) * 32'(INC_R) + 32'(INC_HALF);
    s2_addr_r <= s1_addr_r;
    fq2_r     <= fq_r;
    prod_r    <= PROD_W'(v_r[31:2]) * PROD_W'(INC_RECIP);
    wr_r.addr <= s2_addr_r;
    wr_r.data <= fq2_r + INC_W'(prod_r[PROD_W-1:RECIP_SHIFT]);
  end

  assign wr   = wr_r;
  assign busy = s1_valid_r | s2_valid_r | wr_r.en;

endmodule
